FILE: rtl/kbr_pkg.sv
`timescale 1ns / 1ps

package kbr_pkg;

    localparam int NUM_KEYS = 6;

    localparam logic [1:0] MODE_SPECIAL = 2'd0;
    localparam logic [1:0] MODE_NORMAL  = 2'd1;

    localparam logic [0:0] CFG_SWAP_FN_CTRL = 1'd0;
    localparam logic [0:0] CFG_SWAP_ALT_CMD = 1'd1;

    localparam logic [7:0] BIT_EJECT = 8'h08;
    localparam logic [7:0] BIT_FN    = 8'h10;

    localparam logic [7:0] M_LCTRL = 8'h01;
    localparam logic [7:0] M_LALT  = 8'h04;
    localparam logic [7:0] M_LCMD  = 8'h08;
    localparam logic [7:0] M_RCTRL = 8'h10;
    localparam logic [7:0] M_RALT  = 8'h40;
    localparam logic [7:0] M_RCMD  = 8'h80;

    localparam logic [7:0] U_DELETE = 8'h4C;

    typedef struct packed {
        logic swap_fn_ctrl;
        logic swap_alt_cmd;
    } cfg_t;

    typedef struct packed {
        logic [1:0]                mode;
        logic [7:0]                status_byte;
        logic [7:0]                reserved_byte;
        logic [NUM_KEYS-1:0][7:0]  keys;
    } report_t;

    typedef struct packed {
        logic                      fn_latched;
        logic [7:0]                saved_modifiers;
        logic [7:0]                saved_reserved;
        logic [NUM_KEYS-1:0][7:0]  saved_keys;
        logic [7:0]                extra_key;
        logic [7:0]                extra_modifier;
    } state_t;

    typedef struct packed {
        logic [7:0]                modifiers;
        logic [7:0]                reserved;
        logic [NUM_KEYS-1:0][7:0]  slots;
    } boot_report_t;

    // Fn plus key translation; zero means the key has no translation.
    function automatic logic [7:0] fn_map(input logic [7:0] k);
        logic [7:0] r;
        r = 8'h00;
        if (k >= 8'h3A && k <= 8'h45) begin
            r = k + 8'h2E;
        end else begin
            case (k)
                8'h50: r = 8'h4A;
                8'h4F: r = 8'h4D;
                8'h52: r = 8'h4B;
                8'h51: r = 8'h4E;
                8'h28: r = 8'h49;
                8'h13: r = 8'h46;
                8'h05: r = 8'h48;
                8'h16: r = 8'h47;
                default: r = 8'h00;
            endcase
        end
        return r;
    endfunction

    // Alt takes priority when both bits of a pair are held.
    function automatic logic [7:0] swap_pair(input logic [7:0] m, input logic [7:0] alt,
                                             input logic [7:0] cmd);
        logic [7:0] r;
        r = m;
        if ((m & alt) != 8'h00) begin
            r = (m & ~alt) | cmd;
        end else if ((m & cmd) != 8'h00) begin
            r = (m & ~cmd) | alt;
        end
        return r;
    endfunction

endpackage

FILE: rtl/keyboard_report_remapper_core.sv
`timescale 1ns / 1ps

// Keyboard report remapper.
// Input channel (s_*): one device report per transfer, with its length class in
// s_mode. Result channel (m_*): one boot keyboard report per input transfer,
// in the same order. Configuration channel (cfg_*): writes register 0
// (swap Fn and left Ctrl) or register 1 (swap Alt and Cmd); it is always ready
// and should only be written while no report is in flight.
// An input transfer is first captured in the input register; the remap, state
// update and key compaction then run in one combinational pass into the result
// register. Throughput is one report per cycle while the receiver does not stall;
// the input register and the result register are each one entry deep.
// When the receiver stalls, the result is held and one more report can wait in
// the input register before s_ready drops.
// Reset (aresetn low at a clock edge) empties both stages, clears the Fn latch,
// the saved report, the special key and modifier, and both configuration bits.
module keyboard_report_remapper_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [7:0] s_status_byte,
    input  logic [7:0] s_reserved_byte,
    input  logic [7:0] s_key_a,
    input  logic [7:0] s_key_b,
    input  logic [7:0] s_key_c,
    input  logic [7:0] s_key_d,
    input  logic [7:0] s_key_e,
    input  logic [7:0] s_key_f,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_modifiers_out,
    output logic [7:0] m_reserved_out,
    output logic [7:0] m_slot_a,
    output logic [7:0] m_slot_b,
    output logic [7:0] m_slot_c,
    output logic [7:0] m_slot_d,
    output logic [7:0] m_slot_e,
    output logic [7:0] m_slot_f,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [0:0] cfg_index,
    input  logic [0:0] cfg_wdata
);
    import kbr_pkg::*;

    cfg_t         cfg_reg;
    report_t      in_reg;
    logic         in_valid_reg;
    state_t       state_reg;
    state_t       state_next;
    boot_report_t out_reg;
    boot_report_t out_next;
    logic         m_valid_reg;
    logic         advance;

    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    kbr_remap u_remap (
        .cfg       (cfg_reg),
        .report    (in_reg),
        .state_cur (state_reg),
        .state_nxt (state_next)
    );

    kbr_compact u_compact (
        .state  (state_next),
        .report (out_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SWAP_FN_CTRL: cfg_reg.swap_fn_ctrl <= cfg_wdata[0];
                CFG_SWAP_ALT_CMD: cfg_reg.swap_alt_cmd <= cfg_wdata[0];
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg.mode          <= s_mode;
            in_reg.status_byte   <= s_status_byte;
            in_reg.reserved_byte <= s_reserved_byte;
            in_reg.keys          <= {s_key_f, s_key_e, s_key_d, s_key_c, s_key_b, s_key_a};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_modifiers_out = out_reg.modifiers;
    assign m_reserved_out  = out_reg.reserved;
    assign m_slot_a        = out_reg.slots[0];
    assign m_slot_b        = out_reg.slots[1];
    assign m_slot_c        = out_reg.slots[2];
    assign m_slot_d        = out_reg.slots[3];
    assign m_slot_e        = out_reg.slots[4];
    assign m_slot_f        = out_reg.slots[5];

endmodule

FILE: rtl/kbr_remap.sv
`timescale 1ns / 1ps

module kbr_remap (
    input  kbr_pkg::cfg_t    cfg,
    input  kbr_pkg::report_t report,
    input  kbr_pkg::state_t  state_cur,
    output kbr_pkg::state_t  state_nxt
);
    import kbr_pkg::*;

    logic                     fn;
    logic [7:0]               m;
    logic [7:0]               mapped;
    logic [NUM_KEYS-1:0][7:0] keys;
    logic [7:0]               rsv;

    assign mapped = fn_map(report.keys[0]);

    always_comb begin
        state_nxt = state_cur;
        fn        = state_cur.fn_latched;
        m         = report.status_byte;
        keys      = report.keys;
        rsv       = report.reserved_byte;
        case (report.mode)
            MODE_SPECIAL: begin
                state_nxt.extra_key = ((report.status_byte & BIT_EJECT) != 8'h00) ?
                                      U_DELETE : 8'h00;
                state_nxt.extra_modifier = 8'h00;
                if (cfg.swap_fn_ctrl) begin
                    if ((report.status_byte & BIT_FN) != 8'h00) begin
                        state_nxt.extra_modifier = M_LCTRL;
                    end
                end else begin
                    state_nxt.fn_latched = ((report.status_byte & BIT_FN) != 8'h00);
                end
            end
            MODE_NORMAL: begin
                if (cfg.swap_fn_ctrl) begin
                    if (keys[0] == 8'h00) begin
                        fn = ((m & M_LCTRL) != 8'h00);
                    end
                    m = m & ~M_LCTRL;
                end
                if (cfg.swap_alt_cmd) begin
                    m = swap_pair(swap_pair(m, M_LALT, M_LCMD), M_RALT, M_RCMD);
                end
                if (fn && (keys[0] != 8'h00 || m != 8'h00)) begin
                    if (mapped != 8'h00) begin
                        keys[0] = mapped;
                    end else if ((m & M_LCTRL) != 8'h00) begin
                        m = (m & ~M_LCTRL) | M_RCTRL;
                    end else begin
                        m    = 8'h00;
                        rsv  = 8'h00;
                        keys = '0;
                    end
                end
                state_nxt.fn_latched      = fn;
                state_nxt.saved_modifiers = m;
                state_nxt.saved_reserved  = rsv;
                state_nxt.saved_keys      = keys;
            end
            default: begin
                state_nxt = state_cur;
            end
        endcase
    end

endmodule

FILE: rtl/kbr_compact.sv
`timescale 1ns / 1ps

module kbr_compact (
    input  kbr_pkg::state_t       state,
    output kbr_pkg::boot_report_t report
);
    import kbr_pkg::*;

    logic [NUM_KEYS:0] run;

    // A slot is still in the leading run while every earlier key is nonzero.
    always_comb begin
        run[0] = 1'b1;
        for (int i = 0; i < NUM_KEYS; i++) begin
            run[i+1] = run[i] && (state.saved_keys[i] != 8'h00);
        end
    end

    always_comb begin
        report.modifiers = state.saved_modifiers | state.extra_modifier;
        report.reserved  = state.saved_reserved;
        for (int i = 0; i < NUM_KEYS; i++) begin
            if (run[i+1]) begin
                report.slots[i] = state.saved_keys[i];
            end else if (run[i]) begin
                report.slots[i] = state.extra_key;
            end else begin
                report.slots[i] = 8'h00;
            end
        end
    end

endmodule

FILE: rtl/kbr_checker.sv
`timescale 1ns / 1ps

module kbr_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_modifiers_out,
    input logic [7:0] m_reserved_out,
    input logic [7:0] m_slot_a,
    input logic [7:0] m_slot_b,
    input logic [7:0] m_slot_c,
    input logic [7:0] m_slot_d,
    input logic [7:0] m_slot_e,
    input logic [7:0] m_slot_f
);

    // The result is not valid right after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result keeps its contents.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_modifiers_out) &&
        $stable(m_reserved_out) && $stable(m_slot_a) && $stable(m_slot_b) &&
        $stable(m_slot_c) && $stable(m_slot_d) && $stable(m_slot_e) && $stable(m_slot_f))
        else $error("stalled result changed");

    // The input side only backs up behind a stalled result.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input not ready without a stalled result");

    // An accepted report passes through the input register into the result register when the output is not stalled.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready |=> m_valid)
        else $error("result missing after accepted report");

    // Compaction leaves no key after an empty slot.
    a_compact: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_slot_a != 8'h00 || m_slot_b == 8'h00) &&
        (m_slot_b != 8'h00 || m_slot_c == 8'h00) &&
        (m_slot_c != 8'h00 || m_slot_d == 8'h00) &&
        (m_slot_d != 8'h00 || m_slot_e == 8'h00) &&
        (m_slot_e != 8'h00 || m_slot_f == 8'h00))
        else $error("key slots not compacted");

endmodule

bind keyboard_report_remapper_core kbr_checker u_kbr_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_modifiers_out (m_modifiers_out),
    .m_reserved_out  (m_reserved_out),
    .m_slot_a        (m_slot_a),
    .m_slot_b        (m_slot_b),
    .m_slot_c        (m_slot_c),
    .m_slot_d        (m_slot_d),
    .m_slot_e        (m_slot_e),
    .m_slot_f        (m_slot_f)
);
